@@ hw/rtl/dmn_pkg.sv @@
// ============================================================================
// dmn_pkg - shared types and constants for the distributed mutex node
// Node sizing, opcode and message codes, and the command word passed from
// the front end to the back end through the command queue.
// ============================================================================
package dmn_pkg;

    localparam int MAX_NODE_COUNT = 16;
    localparam int SEQ_BITS       = 16;

    // Fixed field widths of the ports
    localparam int OP_W   = 2;
    localparam int ID_W   = 5;
    localparam int SEQ_W  = 16;
    localparam int KIND_W = 2;
    localparam int CFG_W  = 5;

    localparam int CNT_W  = $clog2(MAX_NODE_COUNT);
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam logic [32:0] SEQ_MAX_W = (33'd1 << SEQ_BITS) - 33'd1;
    localparam logic [SEQ_BITS-1:0] SEQ_MAX = SEQ_BITS'(SEQ_MAX_W);

    // Operation codes
    localparam logic [OP_W-1:0] OP_LREQ = 2'd0;
    localparam logic [OP_W-1:0] OP_IREQ = 2'd1;
    localparam logic [OP_W-1:0] OP_IREP = 2'd2;
    localparam logic [OP_W-1:0] OP_LREL = 2'd3;

    // Message kinds
    localparam logic [KIND_W-1:0] MSG_REQUEST = 2'd0;
    localparam logic [KIND_W-1:0] MSG_REPLY   = 2'd1;
    localparam logic [KIND_W-1:0] MSG_GRANT   = 2'd2;

    // Config register indexes
    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_OWN_ID     = 1'b1;

    localparam logic [CFG_W-1:0] NODE_COUNT_RST = 5'd4;
    localparam logic [CFG_W-1:0] OWN_ID_RST     = 5'd1;

    // Classified word from front to back
    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic                      sender_ok;
        logic [ID_W-1:0]           sender;
        logic [SEQ_BITS-1:0]       seq;
        logic [ID_W-1:0]           own_id;
        logic [CNT_W-1:0]          peers;      // node count minus one
        logic [MAX_NODE_COUNT-1:0] sender_bit;
        logic [MAX_NODE_COUNT-1:0] bcast_mask; // ids that get a request
        logic [MAX_NODE_COUNT-1:0] flush_mask; // ids that may get a reply
    } t_cmd;

    function automatic logic [SEQ_BITS-1:0] seq_clamp(input logic [SEQ_W-1:0] s);
        if (33'(s) > SEQ_MAX_W) begin
            return SEQ_MAX;
        end
        return SEQ_BITS'(s);
    endfunction

endpackage

@@ hw/rtl/dmn_front.sv @@
// ============================================================================
// dmn_front - config registers and input word classification
// Holds node_count/own_id, checks the sender and builds the id masks.
// ============================================================================
module dmn_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [dmn_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic [dmn_pkg::OP_W-1:0]   i_operation,
    input  logic [dmn_pkg::ID_W-1:0]   i_sender_id,
    input  logic [dmn_pkg::SEQ_W-1:0]  i_sequence_number,
    output dmn_pkg::t_cmd              o_cmd
);
    import dmn_pkg::*;

    logic [CFG_W-1:0] r_node_count;
    logic [CFG_W-1:0] r_own_id;

    logic [ID_W-1:0]             eff_n;
    logic [MAX_NODE_COUNT:0]     range_wide;
    logic [MAX_NODE_COUNT-1:0]   range_mask;
    logic [MAX_NODE_COUNT-1:0]   own_bit;
    logic                        own_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_own_id     <= OWN_ID_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NODE_COUNT: r_node_count <= i_cfg_wdata;
                CFG_OWN_ID:     r_own_id     <= i_cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_comb begin
        // clamp node count to 2..MAX
        if (r_node_count < ID_W'(2)) begin
            eff_n = ID_W'(2);
        end else if (r_node_count > ID_W'(MAX_NODE_COUNT)) begin
            eff_n = ID_W'(MAX_NODE_COUNT);
        end else begin
            eff_n = r_node_count;
        end

        range_wide   = ((MAX_NODE_COUNT+1)'(1) << eff_n) - (MAX_NODE_COUNT+1)'(1);
        range_mask   = range_wide[MAX_NODE_COUNT-1:0];
        own_in_range = (r_own_id != '0) && (r_own_id <= eff_n);
        own_bit      = (r_own_id != '0) ?
                       (MAX_NODE_COUNT'(1) << (r_own_id - ID_W'(1))) : '0;

        o_cmd.op         = i_operation;
        o_cmd.sender     = i_sender_id;
        o_cmd.seq        = seq_clamp(i_sequence_number);
        o_cmd.own_id     = r_own_id;
        o_cmd.peers      = CNT_W'(eff_n - ID_W'(1));
        o_cmd.sender_ok  = (i_sender_id != '0) && (i_sender_id <= eff_n) &&
                           (i_sender_id != r_own_id);
        o_cmd.sender_bit = (i_sender_id != '0) ?
                           (MAX_NODE_COUNT'(1) << (i_sender_id - ID_W'(1))) : '0;
        o_cmd.flush_mask = range_mask & ~own_bit;
        // own id outside the node range: top id is dropped, n-1 requests only
        o_cmd.bcast_mask = own_in_range ? (range_mask & ~own_bit) :
                           (range_mask & ~(MAX_NODE_COUNT'(1) << (eff_n - ID_W'(1))));
    end

endmodule

@@ hw/rtl/dmn_cmdq.sv @@
// ============================================================================
// dmn_cmdq - command queue between front and back end
// Small register FIFO of classified words; full drives the input stall.
// ============================================================================
module dmn_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dmn_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output dmn_pkg::t_cmd o_cmd
);
    import dmn_pkg::*;

    localparam int CNT_QW = $clog2(QDEPTH + 1);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [CNT_QW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CNT_QW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_QW'(1);
                2'b01:   r_cnt <= r_cnt - CNT_QW'(1);
                default: ;
            endcase
        end
    end

endmodule

@@ hw/rtl/dmn_back.sv @@
// ============================================================================
// dmn_back - protocol state and message sequencer
// Executes one queued word at a time; broadcasts and flushes walk the id mask
// one id per cycle into the output register, holding on a stalled target id.
// ============================================================================
module dmn_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  dmn_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [dmn_pkg::KIND_W-1:0]  o_message_kind,
    output logic [dmn_pkg::ID_W-1:0]    o_destination_id,
    output logic [dmn_pkg::SEQ_W-1:0]   o_request_value,
    output logic                        o_last
);
    import dmn_pkg::*;

    typedef enum logic {S_IDLE, S_SCAN} t_state;

    t_state                    r_state, n_state;
    logic                      r_req, n_req;
    logic [SEQ_BITS-1:0]       r_own, n_own;
    logic [SEQ_BITS-1:0]       r_hs, n_hs;
    logic [CNT_W-1:0]          r_pend, n_pend;
    logic [MAX_NODE_COUNT-1:0] r_defer, n_defer;
    logic [MAX_NODE_COUNT-1:0] r_mask, n_mask;
    logic [ID_W-1:0]           r_dest, n_dest;
    logic [KIND_W-1:0]         r_kind, n_kind;
    logic [SEQ_W-1:0]          r_sval, n_sval;
    logic                      r_out_valid, n_out_valid;
    logic [KIND_W-1:0]         r_o_kind, n_o_kind;
    logic [ID_W-1:0]           r_o_dest, n_o_dest;
    logic [SEQ_W-1:0]          r_o_val, n_o_val;
    logic                      r_o_last, n_o_last;

    logic                slot_free;
    logic                pop;
    logic                scan_end;
    logic                defer;
    logic [SEQ_BITS-1:0] new_own;

    assign slot_free = !r_out_valid || !i_stall;
    assign scan_end  = (r_mask[MAX_NODE_COUNT-1:1] == '0);
    assign new_own   = (r_hs == SEQ_MAX) ? SEQ_MAX : r_hs + SEQ_BITS'(1);
    assign defer     = r_req && ((i_cmd.seq > r_own) ||
                       ((i_cmd.seq == r_own) && (i_cmd.sender > i_cmd.own_id)));

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_own       = r_own;
        n_hs        = r_hs;
        n_pend      = r_pend;
        n_defer     = r_defer;
        n_mask      = r_mask;
        n_dest      = r_dest;
        n_kind      = r_kind;
        n_sval      = r_sval;
        n_out_valid = r_out_valid && i_stall;
        n_o_kind    = r_o_kind;
        n_o_dest    = r_o_dest;
        n_o_val     = r_o_val;
        n_o_last    = r_o_last;
        pop         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid && slot_free) begin
                    pop = 1'b1;
                    case (i_cmd.op)
                        OP_LREQ: begin
                            if (!r_req) begin
                                n_req   = 1'b1;
                                n_own   = new_own;
                                n_pend  = i_cmd.peers;
                                n_mask  = i_cmd.bcast_mask;
                                n_dest  = ID_W'(1);
                                n_kind  = MSG_REQUEST;
                                n_sval  = SEQ_W'(new_own);
                                n_state = S_SCAN;
                            end
                        end
                        OP_IREQ: begin
                            if (i_cmd.sender_ok) begin
                                if (i_cmd.seq > r_hs) begin
                                    n_hs = i_cmd.seq;
                                end
                                if (defer) begin
                                    n_defer = r_defer | i_cmd.sender_bit;
                                end else begin
                                    n_out_valid = 1'b1;
                                    n_o_kind    = MSG_REPLY;
                                    n_o_dest    = i_cmd.sender;
                                    n_o_val     = '0;
                                    n_o_last    = 1'b1;
                                end
                            end
                        end
                        OP_IREP: begin
                            if (i_cmd.sender_ok && r_req && (r_pend != '0)) begin
                                n_pend = r_pend - CNT_W'(1);
                                if (r_pend == CNT_W'(1)) begin
                                    n_out_valid = 1'b1;
                                    n_o_kind    = MSG_GRANT;
                                    n_o_dest    = '0;
                                    n_o_val     = '0;
                                    n_o_last    = 1'b1;
                                end
                            end
                        end
                        OP_LREL: begin
                            if (r_req) begin
                                n_req   = 1'b0;
                                n_pend  = '0;
                                n_defer = '0;
                                n_mask  = r_defer & i_cmd.flush_mask;
                                n_dest  = ID_W'(1);
                                n_kind  = MSG_REPLY;
                                n_sval  = '0;
                                if ((r_defer & i_cmd.flush_mask) != '0) begin
                                    n_state = S_SCAN;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (!r_mask[0] || slot_free) begin
                    if (r_mask[0]) begin
                        n_out_valid = 1'b1;
                        n_o_kind    = r_kind;
                        n_o_dest    = r_dest;
                        n_o_val     = r_sval;
                        n_o_last    = scan_end;
                    end
                    n_mask = r_mask >> 1;
                    n_dest = r_dest + ID_W'(1);
                    if (scan_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req       <= 1'b0;
            r_own       <= '0;
            r_hs        <= '0;
            r_pend      <= '0;
            r_defer     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_req       <= n_req;
            r_own       <= n_own;
            r_hs        <= n_hs;
            r_pend      <= n_pend;
            r_defer     <= n_defer;
            r_out_valid <= n_out_valid;
            r_mask      <= n_mask;
            r_dest      <= n_dest;
            r_kind      <= n_kind;
            r_sval      <= n_sval;
            r_o_kind    <= n_o_kind;
            r_o_dest    <= n_o_dest;
            r_o_val     <= n_o_val;
            r_o_last    <= n_o_last;
        end
    end

    assign o_pop            = pop;
    assign o_valid          = r_out_valid;
    assign o_message_kind   = r_o_kind;
    assign o_destination_id = r_o_dest;
    assign o_request_value  = r_o_val;
    assign o_last           = r_o_last;

endmodule

@@ hw/rtl/distributed_mutex_node_top.sv @@
// ============================================================================
// distributed_mutex_node_top - one node of Ricart-Agrawala mutual exclusion
// Front end classifies input words, a short command queue decouples it from
// the back end that holds protocol state and sequences outgoing messages.
// ============================================================================
//
//  channel   | handshake           | payload
//  ----------+---------------------+---------------------------------------
//  input     | i_valid / o_stall   | i_operation, i_sender_id,
//            |                     | i_sequence_number
//  output    | o_valid / i_stall   | o_message_kind, o_destination_id,
//            |                     | o_request_value, o_last
//  config    | i_cfg_we            | i_cfg_index, i_cfg_wdata
//
//  A word producing at most one message needs no id scan in the back end.
//  A local request, or a release with deferred replies, is dispatched and
//  then walks the id mask one id per cycle, pausing at a target id while the
//  output stalls, up to its highest target id (back-end id scanner).
//  Input words are taken while the queue has room, up to 2 ahead of the back.
//  Reset (synchronous, active low) clears protocol state, queue and output.
//  Output stall holds the output register and pauses the scanner at a target id.
//
module distributed_mutex_node_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config port
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [dmn_pkg::CFG_W-1:0]   i_cfg_wdata,
    // input word
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [dmn_pkg::OP_W-1:0]    i_operation,
    input  logic [dmn_pkg::ID_W-1:0]    i_sender_id,
    input  logic [dmn_pkg::SEQ_W-1:0]   i_sequence_number,
    // output word
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [dmn_pkg::KIND_W-1:0]  o_message_kind,
    output logic [dmn_pkg::ID_W-1:0]    o_destination_id,
    output logic [dmn_pkg::SEQ_W-1:0]   o_request_value,
    output logic                        o_last
);
    import dmn_pkg::*;

    t_cmd front_cmd;   // classified input word
    t_cmd q_cmd;       // head of queue
    logic q_full;
    logic q_valid;
    logic q_pop;

    // Front: config registers, sender check, id masks
    dmn_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_operation       (i_operation),
        .i_sender_id       (i_sender_id),
        .i_sequence_number (i_sequence_number),
        .o_cmd             (front_cmd)
    );

    // Queue: a word is accepted when valid and the queue is not full
    dmn_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    assign o_stall = q_full;

    // Back: protocol state, broadcast/flush sequencer, output register
    dmn_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_cmd            (q_cmd),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_message_kind   (o_message_kind),
        .o_destination_id (o_destination_id),
        .o_request_value  (o_request_value),
        .o_last           (o_last)
    );

endmodule

@@ hw/rtl/dmn_chk.sv @@
// ============================================================================
// dmn_chk - port-level checks for the distributed mutex node
// Watches the output channel; bound to the top level below.
// ============================================================================
module dmn_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [dmn_pkg::KIND_W-1:0]  o_message_kind,
    input logic [dmn_pkg::ID_W-1:0]    o_destination_id,
    input logic [dmn_pkg::SEQ_W-1:0]   o_request_value,
    input logic                        o_last
);
    import dmn_pkg::*;

    // stalled word stays up
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped while stalled");

    // no word right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // grant is a single final word with no target
    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_message_kind == MSG_GRANT) |->
        o_last && (o_destination_id == '0) && (o_request_value == '0))
        else $error("malformed grant");

    // replies carry no number and go to a real node
    a_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_message_kind == MSG_REPLY) |->
        (o_request_value == '0) && (o_destination_id != '0))
        else $error("malformed reply");

    // only defined kinds; requests target a real node
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_message_kind == MSG_REQUEST && o_destination_id != '0) ||
        o_message_kind == MSG_REPLY || o_message_kind == MSG_GRANT)
        else $error("bad message kind or request target");

endmodule

bind distributed_mutex_node_top dmn_chk u_dmn_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_message_kind   (o_message_kind),
    .o_destination_id (o_destination_id),
    .o_request_value  (o_request_value),
    .o_last           (o_last)
);
